[hdl/piav_pkg.sv]
// ----------------------------------------------------------------------------
// PIA/VIA I/O page package
// Shared codes, register offsets, constants and the item and result types.
// ----------------------------------------------------------------------------
package piav_pkg;

    // Request type codes.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TIMER_RELOAD = 1'b0;
    localparam logic CFG_FRAME_PERIOD = 1'b1;

    localparam int CFG_DATA_W     = 16;
    localparam int FRAME_CNT_W    = 10;
    localparam int TIMER_W        = 16;

    localparam logic [FRAME_CNT_W-1:0] FRAME_PERIOD_RESET = 10'd50;

    // Register offsets within the page.
    localparam logic [7:0] OFF_PIA1_PA   = 8'h10;
    localparam logic [7:0] OFF_PIA1_CRA  = 8'h11;
    localparam logic [7:0] OFF_PIA1_PB   = 8'h12;
    localparam logic [7:0] OFF_PIA1_CRB  = 8'h13;
    localparam logic [7:0] OFF_PIA2_PA   = 8'h20;
    localparam logic [7:0] OFF_PIA2_CRA  = 8'h21;
    localparam logic [7:0] OFF_PIA2_PB   = 8'h22;
    localparam logic [7:0] OFF_PIA2_CRB  = 8'h23;
    localparam logic [7:0] OFF_VIA_ORB   = 8'h40;
    localparam logic [7:0] OFF_VIA_ORA   = 8'h41;
    localparam logic [7:0] OFF_VIA_DDRB  = 8'h42;
    localparam logic [7:0] OFF_VIA_DDRA  = 8'h43;
    localparam logic [7:0] OFF_VIA_T1CH  = 8'h45;
    localparam logic [7:0] OFF_VIA_PCR   = 8'h4C;
    localparam logic [7:0] OFF_VIA_IFR   = 8'h4D;
    localparam logic [7:0] OFF_VIA_IER   = 8'h4E;

    // Fixed read values and bit masks.
    localparam logic [7:0] RD_PIA1_PA     = 8'h8F;
    localparam logic [7:0] RD_PIA1_CRA    = 8'h00;
    localparam logic [7:0] RD_PIA1_PB     = 8'h0F;
    localparam logic [7:0] RD_UNHANDLED   = 8'hCD;
    localparam logic [7:0] IFR_PORTB_MASK = 8'h18;
    localparam logic [7:0] IFR_PORTA_MASK = 8'h03;
    localparam logic [7:0] IFR_T1_MASK    = 8'h40;
    localparam logic [7:0] PB_FRAME_MASK  = 8'h20;
    localparam int         IER_T1_BIT     = 6;
    localparam int         IER_SET_BIT    = 7;
    localparam int         CR_DATA_SEL    = 2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] reg_offset;
        logic [7:0] write_value;
        logic       cpu_irq_masked;
    } piav_item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       irq_pulse;
        logic       screen_refresh;
        logic       unhandled_access;
    } piav_result_t;

endpackage

[hdl/piav_io_regs.sv]
// ----------------------------------------------------------------------------
// PIA/VIA register file and request logic
// Holds the PIA, VIA, timer and frame counter state and works out the result
// of one request; state is committed when step_en is high.
// ----------------------------------------------------------------------------
module piav_io_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  piav_pkg::piav_item_t            item,
    output piav_pkg::piav_result_t          result,
    input  logic                            cfg_write_en,
    input  logic                            cfg_index,
    input  logic [piav_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [7:0] pia_port_reg [4];
    logic [7:0] pia_port_next [4];
    logic [7:0] pia_ddr_reg [4];
    logic [7:0] pia_ddr_next [4];
    logic [7:0] pia_ctrl_reg [4];
    logic [7:0] pia_ctrl_next [4];
    logic [7:0] via_port_a_reg, via_port_a_next;
    logic [7:0] via_port_b_reg, via_port_b_next;
    logic [7:0] via_ddr_a_reg, via_ddr_a_next;
    logic [7:0] via_ddr_b_reg, via_ddr_b_next;
    logic [7:0] via_pcr_reg, via_pcr_next;
    logic [7:0] via_ifr_reg, via_ifr_next;
    logic [6:0] via_ier_reg, via_ier_next;
    logic [piav_pkg::TIMER_W-1:0]     timer_count_reg, timer_count_next;
    logic                             timer_running_reg, timer_running_next;
    logic [piav_pkg::FRAME_CNT_W-1:0] frame_count_reg, frame_count_next;
    logic [piav_pkg::TIMER_W-1:0]     timer_reload_reg;
    logic [piav_pkg::FRAME_CNT_W-1:0] frame_period_reg;
    logic [1:0]                       pia_side;
    logic                             pia_port_wr;

    always_comb
    begin
        pia_port_next   = pia_port_reg;
        pia_ddr_next    = pia_ddr_reg;
        pia_ctrl_next   = pia_ctrl_reg;
        via_port_a_next = via_port_a_reg;
        via_port_b_next = via_port_b_reg;
        via_ddr_a_next  = via_ddr_a_reg;
        via_ddr_b_next  = via_ddr_b_reg;
        via_pcr_next    = via_pcr_reg;
        via_ifr_next    = via_ifr_reg;
        via_ier_next    = via_ier_reg;
        timer_count_next   = timer_count_reg;
        timer_running_next = timer_running_reg;
        frame_count_next   = frame_count_reg;
        result      = '0;
        pia_side    = 2'd0;
        pia_port_wr = 1'b0;

        unique case (item.req_type)
            piav_pkg::REQ_READ:
            begin
                case (item.reg_offset)
                    piav_pkg::OFF_PIA1_PA:  result.read_value = piav_pkg::RD_PIA1_PA;
                    piav_pkg::OFF_PIA1_CRA: result.read_value = piav_pkg::RD_PIA1_CRA;
                    piav_pkg::OFF_PIA1_PB:  result.read_value = piav_pkg::RD_PIA1_PB;
                    piav_pkg::OFF_PIA2_PA:  result.read_value = pia_port_reg[2];
                    piav_pkg::OFF_PIA2_PB:  result.read_value = pia_port_reg[3];
                    piav_pkg::OFF_VIA_ORB:
                    begin
                        result.read_value = via_port_b_reg;
                        via_ifr_next = via_ifr_reg & ~piav_pkg::IFR_PORTB_MASK;
                    end
                    default:
                    begin
                        result.read_value       = piav_pkg::RD_UNHANDLED;
                        result.unhandled_access = 1'b1;
                    end
                endcase
            end
            piav_pkg::REQ_WRITE:
            begin
                case (item.reg_offset)
                    piav_pkg::OFF_PIA1_PA:
                    begin
                        pia_side = 2'd0;
                        pia_port_wr = 1'b1;
                    end
                    piav_pkg::OFF_PIA1_PB:
                    begin
                        pia_side = 2'd1;
                        pia_port_wr = 1'b1;
                    end
                    piav_pkg::OFF_PIA2_PA:
                    begin
                        pia_side = 2'd2;
                        pia_port_wr = 1'b1;
                    end
                    piav_pkg::OFF_PIA2_PB:
                    begin
                        pia_side = 2'd3;
                        pia_port_wr = 1'b1;
                    end
                    piav_pkg::OFF_PIA1_CRA: pia_ctrl_next[0] = item.write_value;
                    piav_pkg::OFF_PIA1_CRB: pia_ctrl_next[1] = item.write_value;
                    piav_pkg::OFF_PIA2_CRA: pia_ctrl_next[2] = item.write_value;
                    piav_pkg::OFF_PIA2_CRB: pia_ctrl_next[3] = item.write_value;
                    piav_pkg::OFF_VIA_ORB:
                    begin
                        via_port_b_next = item.write_value & via_ddr_b_reg;
                        via_ifr_next    = via_ifr_reg & ~piav_pkg::IFR_PORTB_MASK;
                    end
                    piav_pkg::OFF_VIA_ORA:
                    begin
                        via_port_a_next = item.write_value & via_ddr_a_reg;
                        via_ifr_next    = via_ifr_reg & ~piav_pkg::IFR_PORTA_MASK;
                    end
                    piav_pkg::OFF_VIA_DDRB: via_ddr_b_next = item.write_value;
                    piav_pkg::OFF_VIA_DDRA: via_ddr_a_next = item.write_value;
                    piav_pkg::OFF_VIA_T1CH:
                    begin
                        timer_count_next   = timer_reload_reg;
                        timer_running_next = 1'b1;
                        via_ifr_next       = via_ifr_reg & ~piav_pkg::IFR_T1_MASK;
                    end
                    piav_pkg::OFF_VIA_PCR: via_pcr_next = item.write_value;
                    piav_pkg::OFF_VIA_IFR: via_ifr_next = via_ifr_reg & ~item.write_value;
                    piav_pkg::OFF_VIA_IER:
                    begin
                        if (item.write_value[piav_pkg::IER_SET_BIT])
                        begin
                            via_ier_next = via_ier_reg | item.write_value[6:0];
                        end
                        else
                        begin
                            via_ier_next = via_ier_reg & ~item.write_value[6:0];
                        end
                    end
                    default: result.unhandled_access = 1'b1;
                endcase

                // Bit 2 of the side's control register picks data over direction.
                if (pia_port_wr)
                begin
                    if (pia_ctrl_reg[pia_side][piav_pkg::CR_DATA_SEL])
                    begin
                        pia_port_next[pia_side] = item.write_value;
                    end
                    else
                    begin
                        pia_ddr_next[pia_side] = item.write_value;
                    end
                end
            end
            piav_pkg::REQ_TICK:
            begin
                if (frame_count_reg == frame_period_reg)
                begin
                    frame_count_next      = '0;
                    via_port_b_next       = via_port_b_reg | piav_pkg::PB_FRAME_MASK;
                    result.screen_refresh = ~item.cpu_irq_masked;
                    result.irq_pulse      = 1'b1;
                end
                else
                begin
                    frame_count_next = frame_count_reg + 1'b1;
                    via_port_b_next  = via_port_b_reg & ~piav_pkg::PB_FRAME_MASK;
                end

                if (timer_running_reg)
                begin
                    if (timer_count_reg == '0)
                    begin
                        timer_count_next   = '0;
                        timer_running_next = 1'b0;
                        via_ifr_next       = via_ifr_reg | piav_pkg::IFR_T1_MASK;
                        if (via_ier_reg[piav_pkg::IER_T1_BIT])
                        begin
                            result.irq_pulse = 1'b1;
                        end
                    end
                    else
                    begin
                        timer_count_next = timer_count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pia_port_reg[i] <= '0;
                pia_ddr_reg[i]  <= '0;
                pia_ctrl_reg[i] <= '0;
            end
            via_port_a_reg    <= '0;
            via_port_b_reg    <= '0;
            via_ddr_a_reg     <= '0;
            via_ddr_b_reg     <= '0;
            via_pcr_reg       <= '0;
            via_ifr_reg       <= '0;
            via_ier_reg       <= '0;
            timer_count_reg   <= '0;
            timer_running_reg <= 1'b0;
            frame_count_reg   <= '0;
        end
        else if (step_en)
        begin
            pia_port_reg      <= pia_port_next;
            pia_ddr_reg       <= pia_ddr_next;
            pia_ctrl_reg      <= pia_ctrl_next;
            via_port_a_reg    <= via_port_a_next;
            via_port_b_reg    <= via_port_b_next;
            via_ddr_a_reg     <= via_ddr_a_next;
            via_ddr_b_reg     <= via_ddr_b_next;
            via_pcr_reg       <= via_pcr_next;
            via_ifr_reg       <= via_ifr_next;
            via_ier_reg       <= via_ier_next;
            timer_count_reg   <= timer_count_next;
            timer_running_reg <= timer_running_next;
            frame_count_reg   <= frame_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reload_reg <= '0;
            frame_period_reg <= piav_pkg::FRAME_PERIOD_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                piav_pkg::CFG_TIMER_RELOAD: timer_reload_reg <= cfg_data;
                piav_pkg::CFG_FRAME_PERIOD:
                    frame_period_reg <= cfg_data[piav_pkg::FRAME_CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

[hdl/pia_via_io_block.sv]
// ----------------------------------------------------------------------------
// PIA/VIA I/O page
// Two PIAs, one VIA with timer 1 and a periodic frame tick behind one
// request channel and one result channel.
// ----------------------------------------------------------------------------
// Every request beat (read, write or tick) yields exactly one result beat.
// The block takes one request per clock cycle unless the output stalls:
// a request is captured in the input register, and then the register
// file works out its result and commits its state changes as the result
// moves into the output register. Since state is committed at
// that single point, the next request in the input register always sees the
// effect of the one before it. When the output side stalls, the result
// register holds, the input register holds behind it, and in_ready drops
// only once both are full. Configuration writes go straight to the timer
// reload and frame period registers and are meant to be made while no
// request is in flight.
module pia_via_io_block
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [7:0]                      reg_offset,
    input  logic [7:0]                      write_value,
    input  logic                            cpu_irq_masked,
    // Result channel.
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      read_value,
    output logic                            irq_pulse,
    output logic                            screen_refresh,
    output logic                            unhandled_access,
    // Configuration write port.
    input  logic                            cfg_write_en,
    input  logic                            cfg_index,
    input  logic [piav_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                   in_valid_reg;
    piav_pkg::piav_item_t   item_reg;
    logic                   out_valid_reg;
    piav_pkg::piav_result_t result_reg;
    piav_pkg::piav_result_t result_next;
    logic                   advance;
    logic                   step_en;

    // The result register can take a new beat when empty or being drained.
    assign advance  = !out_valid_reg || out_ready;
    assign step_en  = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Payload needs no reset; it is qualified by in_valid_reg.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.req_type       <= req_type;
            item_reg.reg_offset     <= reg_offset;
            item_reg.write_value    <= write_value;
            item_reg.cpu_irq_masked <= cpu_irq_masked;
        end
    end

    piav_io_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .item         (item_reg),
        .result       (result_next),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_value       = result_reg.read_value;
    assign irq_pulse        = result_reg.irq_pulse;
    assign screen_refresh   = result_reg.screen_refresh;
    assign unhandled_access = result_reg.unhandled_access;

`ifndef SYNTHESIS
    // A screen refresh only comes with the frame interrupt.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && screen_refresh |-> irq_pulse)
        else $error("screen refresh without interrupt");

    // Tick outputs and the unhandled flag never appear on the same beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unhandled_access |-> !irq_pulse && !screen_refresh)
        else $error("unhandled access on a tick result");

    // Backpressure reaches the input only when both registers are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

    // A committed request always shows up as a result beat next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid)
        else $error("committed request lost");
`endif

endmodule
